>>> rtl/ac_ir_frame_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IR frame decoder core
// Clocked, reset-qualified implication checks reported through $error.
// ----------------------------------------------------------------------------
`ifndef AC_IR_FRAME_DECODER_CORE_ASSERT_SVH
`define AC_IR_FRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define ACIRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACIRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/acird_pkg.sv
// ----------------------------------------------------------------------------
// acird_pkg
// Shared types and constants of the IR frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acird_pkg;

    localparam int NUM_SLOTS = 13;

    // Capture slots for the bytes that the record needs
    localparam logic [3:0] SLOT_B0   = 4'd0;
    localparam logic [3:0] SLOT_B1   = 4'd1;
    localparam logic [3:0] SLOT_B2   = 4'd2;
    localparam logic [3:0] SLOT_B4   = 4'd3;
    localparam logic [3:0] SLOT_B5   = 4'd4;
    localparam logic [3:0] SLOT_B7   = 4'd5;
    localparam logic [3:0] SLOT_B8   = 4'd6;
    localparam logic [3:0] SLOT_B9   = 4'd7;
    localparam logic [3:0] SLOT_B12  = 4'd8;
    localparam logic [3:0] SLOT_B13  = 4'd9;
    localparam logic [3:0] SLOT_B14  = 4'd10;
    localparam logic [3:0] SLOT_RT   = 4'd11;
    localparam logic [3:0] SLOT_ID   = 4'd12;
    localparam logic [3:0] SLOT_NONE = 4'd15;

    localparam logic [8:0] PC_IFEEL       = 9'd19;
    localparam logic [8:0] PC_THREE       = 9'd213;
    localparam logic [8:0] PC_THREE_IFEEL = 9'd232;
    localparam logic [8:0] PC_FOUR        = 9'd284;
    localparam logic [8:0] PC_FOUR_IFEEL  = 9'd303;

    localparam logic [3:0] CHK_OFFSET = 4'hA;
    localparam logic [7:0] IFEEL_ID   = 8'hA5;
    localparam logic [3:0] TIMER_MIN  = 4'hA;
    localparam logic [5:0] POS_MAX    = 6'd63;

    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_IFEEL  = 2'd1,
        KIND_THREE  = 2'd2,
        KIND_FOUR   = 2'd3
    } kind_t;

    // Frame state as it stands after the current byte
    typedef struct packed {
        kind_t                         kind;
        logic                          has_ifeel;
        logic                          sums_good;
        logic [3:0]                    block_sum;
        logic [5:0]                    count;
        logic [NUM_SLOTS-1:0][7:0]     cap;
    } snapshot_t;

    typedef struct packed {
        kind_t       frame_kind;
        logic [3:0]  check_flags;
        logic        power_on;
        logic [2:0]  op_mode;
        logic [4:0]  set_temp_c;
        logic [2:0]  fan_level;
        logic [6:0]  feature_flags;
        logic [1:0]  sleep_mode;
        logic [7:0]  vane_positions;
        logic [1:0]  display_source;
        logic [7:0]  room_temp_c;
        logic [10:0] timer_minutes;
    } record_t;

endpackage

>>> rtl/acird_if.sv
// ----------------------------------------------------------------------------
// acird_in_if / acird_out_if
// Valid/ready channels for received bytes and decoded records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface acird_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [8:0] pulse_count;
    logic       last_byte;

    modport source (output valid, output frame_byte, output pulse_count,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input pulse_count,
                    input last_byte, output ready);
endinterface

interface acird_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [3:0]  check_flags;
    logic        power_on;
    logic [2:0]  op_mode;
    logic [4:0]  set_temp_c;
    logic [2:0]  fan_level;
    logic [6:0]  feature_flags;
    logic [1:0]  sleep_mode;
    logic [7:0]  vane_positions;
    logic [1:0]  display_source;
    logic [7:0]  room_temp_c;
    logic [10:0] timer_minutes;

    modport source (output valid, output frame_kind, output check_flags,
                    output power_on, output op_mode, output set_temp_c,
                    output fan_level, output feature_flags, output sleep_mode,
                    output vane_positions, output display_source,
                    output room_temp_c, output timer_minutes, input ready);
    modport sink   (input valid, input frame_kind, input check_flags,
                    input power_on, input op_mode, input set_temp_c,
                    input fan_level, input feature_flags, input sleep_mode,
                    input vane_positions, input display_source,
                    input room_temp_c, input timer_minutes, output ready);
endinterface

>>> rtl/ac_ir_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// ac_ir_frame_decoder_core
// Decodes air-conditioner remote frames, one received byte per transfer.
// ----------------------------------------------------------------------------
//  channel      dir  payload                                   emits
//  byte_in      in   frame_byte, pulse_count, last_byte         every byte
//  record_out   out  decoded record, twelve fields              last byte only
//
//  One byte per cycle while byte_in is not stalled: the frame state updates
//  at the byte transfer and the record is loaded into the output register at the
//  last byte's transfer, appears in the next cycle and is held until taken.
//  Reset clears the frame position, checks and captured bytes.
//  byte_in stalls only while a record waits and record_out is not ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ac_ir_frame_decoder_core_assert.svh"

module ac_ir_frame_decoder_core (
    input  logic               clk,
    input  logic               rst_n,
    acird_in_if.sink           byte_in,
    acird_out_if.source        record_out
);

    acird_pkg::snapshot_t snap;
    acird_pkg::record_t   rec;
    acird_pkg::record_t   rec_reg;
    logic                 out_valid_reg;
    logic                 accept;

    assign byte_in.ready = !out_valid_reg || record_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    acird_frame_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .frame_byte  (byte_in.frame_byte),
        .pulse_count (byte_in.pulse_count),
        .last_byte   (byte_in.last_byte),
        .snap        (snap)
    );

    acird_record_decode u_decode (
        .snap (snap),
        .rec  (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && byte_in.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (record_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // record payload: load on the last byte, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept && byte_in.last_byte)
        begin
            rec_reg <= rec;
        end
    end

    assign record_out.valid          = out_valid_reg;
    assign record_out.frame_kind     = rec_reg.frame_kind;
    assign record_out.check_flags    = rec_reg.check_flags;
    assign record_out.power_on       = rec_reg.power_on;
    assign record_out.op_mode        = rec_reg.op_mode;
    assign record_out.set_temp_c     = rec_reg.set_temp_c;
    assign record_out.fan_level      = rec_reg.fan_level;
    assign record_out.feature_flags  = rec_reg.feature_flags;
    assign record_out.sleep_mode     = rec_reg.sleep_mode;
    assign record_out.vane_positions = rec_reg.vane_positions;
    assign record_out.display_source = rec_reg.display_source;
    assign record_out.room_temp_c    = rec_reg.room_temp_c;
    assign record_out.timer_minutes  = rec_reg.timer_minutes;

    `ACIRD_ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n,
        out_valid_reg && !record_out.ready, !byte_in.ready,
        "byte taken while a record is stalled")
    `ACIRD_ASSERT_NEXT(a_last_gives_record, clk, rst_n,
        accept && byte_in.last_byte, out_valid_reg,
        "no record after the last byte")
    `ACIRD_ASSERT_IMPLY(a_reject_is_empty, clk, rst_n,
        out_valid_reg && (rec_reg.frame_kind == acird_pkg::KIND_REJECT),
        (rec_reg.check_flags == 4'd0) && (rec_reg.set_temp_c == 5'd0),
        "rejected frame carries decoded fields")

endmodule

>>> rtl/acird_frame_track.sv
// ----------------------------------------------------------------------------
// acird_frame_track
// Per-byte frame state: position, kind, block checksums and captured bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acird_frame_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          frame_byte,
    input  logic [8:0]          pulse_count,
    input  logic                last_byte,
    output acird_pkg::snapshot_t snap
);

    logic [5:0]                               pos_reg;
    acird_pkg::kind_t                         kind_reg;
    logic                                     ifeel_reg;
    logic [3:0]                               sum_reg;
    logic                                     good_reg;
    logic [acird_pkg::NUM_SLOTS-1:0][7:0]     cap_reg;

    acird_pkg::kind_t                         kind_next;
    logic                                     ifeel_next;
    logic [3:0]                               sum_base;
    logic [3:0]                               sum_in;
    logic [3:0]                               sum_next;
    logic                                     good_next;
    logic [acird_pkg::NUM_SLOTS-1:0][7:0]     cap_base;
    logic [acird_pkg::NUM_SLOTS-1:0][7:0]     cap_next;
    logic [5:0]                               limit;
    logic [5:0]                               ifeel_pos;
    logic [3:0]                               slot;
    logic [5:0]                               count_next;
    logic [2:0]                               off;
    logic                                     start;

    always_comb
    begin
        start = (pos_reg == 6'd0);

        kind_next  = kind_reg;
        ifeel_next = ifeel_reg;
        if (start)
        begin
            unique case (pulse_count)
                acird_pkg::PC_IFEEL:
                begin
                    kind_next  = acird_pkg::KIND_IFEEL;
                    ifeel_next = 1'b1;
                end
                acird_pkg::PC_THREE:
                begin
                    kind_next  = acird_pkg::KIND_THREE;
                    ifeel_next = 1'b0;
                end
                acird_pkg::PC_THREE_IFEEL:
                begin
                    kind_next  = acird_pkg::KIND_THREE;
                    ifeel_next = 1'b1;
                end
                acird_pkg::PC_FOUR:
                begin
                    kind_next  = acird_pkg::KIND_FOUR;
                    ifeel_next = 1'b0;
                end
                acird_pkg::PC_FOUR_IFEEL:
                begin
                    kind_next  = acird_pkg::KIND_FOUR;
                    ifeel_next = 1'b1;
                end
                default:
                begin
                    kind_next  = acird_pkg::KIND_REJECT;
                    ifeel_next = 1'b0;
                end
            endcase
        end

        // a new frame restarts the checks and drops old captures
        sum_base  = start ? 4'd0 : sum_reg;
        good_next = start ? 1'b1 : good_reg;
        cap_base  = start ? '0 : cap_reg;

        case (kind_next)
            acird_pkg::KIND_THREE: limit = 6'd24;
            acird_pkg::KIND_FOUR:  limit = 6'd32;
            default:               limit = 6'd0;
        endcase

        off      = pos_reg[2:0];
        sum_in   = (off == 3'd0) ? acird_pkg::CHK_OFFSET : sum_base;
        sum_next = sum_base;
        if (pos_reg < limit)
        begin
            if (off < 3'd4)
            begin
                sum_next = sum_in + frame_byte[3:0];
            end
            else if (off < 3'd7)
            begin
                sum_next = sum_in + frame_byte[7:4];
            end
            else
            begin
                if (frame_byte[7:4] != sum_in)
                begin
                    good_next = 1'b0;
                end
                sum_next = 4'd0;
            end
        end

        ifeel_pos = (kind_next == acird_pkg::KIND_FOUR) ? 6'd32 : 6'd24;
        slot      = acird_pkg::SLOT_NONE;
        if (kind_next == acird_pkg::KIND_IFEEL)
        begin
            if (pos_reg == 6'd0)
            begin
                slot = acird_pkg::SLOT_RT;
            end
            else if (pos_reg == 6'd1)
            begin
                slot = acird_pkg::SLOT_ID;
            end
        end
        else if (kind_next != acird_pkg::KIND_REJECT)
        begin
            unique case (pos_reg)
                6'd0:    slot = acird_pkg::SLOT_B0;
                6'd1:    slot = acird_pkg::SLOT_B1;
                6'd2:    slot = acird_pkg::SLOT_B2;
                6'd4:    slot = acird_pkg::SLOT_B4;
                6'd5:    slot = acird_pkg::SLOT_B5;
                6'd7:    slot = acird_pkg::SLOT_B7;
                6'd8:    slot = acird_pkg::SLOT_B8;
                6'd9:    slot = acird_pkg::SLOT_B9;
                6'd12:   slot = acird_pkg::SLOT_B12;
                6'd13:   slot = acird_pkg::SLOT_B13;
                6'd14:   slot = acird_pkg::SLOT_B14;
                default:
                begin
                    if (ifeel_next && (pos_reg == ifeel_pos))
                    begin
                        slot = acird_pkg::SLOT_RT;
                    end
                    else if (ifeel_next && (pos_reg == ifeel_pos + 6'd1))
                    begin
                        slot = acird_pkg::SLOT_ID;
                    end
                end
            endcase
        end

        for (int i = 0; i < acird_pkg::NUM_SLOTS; i++)
        begin
            cap_next[i] = (slot == 4'(i)) ? frame_byte : cap_base[i];
        end

        count_next = (pos_reg == acird_pkg::POS_MAX) ? pos_reg : pos_reg + 6'd1;

        snap.kind      = kind_next;
        snap.has_ifeel = ifeel_next;
        snap.sums_good = good_next;
        snap.block_sum = sum_next;
        snap.count     = count_next;
        snap.cap       = cap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 6'd0;
            kind_reg  <= acird_pkg::KIND_REJECT;
            ifeel_reg <= 1'b0;
            sum_reg   <= 4'd0;
            good_reg  <= 1'b1;
            cap_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= last_byte ? 6'd0 : count_next;
            kind_reg  <= kind_next;
            ifeel_reg <= ifeel_next;
            sum_reg   <= sum_next;
            good_reg  <= good_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

>>> rtl/acird_record_decode.sv
// ----------------------------------------------------------------------------
// acird_record_decode
// Turns the frame state after the last byte into one decoded record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acird_record_decode (
    input  acird_pkg::snapshot_t snap,
    output acird_pkg::record_t   rec
);

    logic [7:0] b0, b1, b2, b4, b5, b7, b8, b9, b12, b13, b14;
    logic [7:0] rt;
    logic [2:0] nblocks;
    logic [2:0] reached;
    logic       ok;
    logic [3:0] flags;

    always_comb
    begin
        b0  = snap.cap[acird_pkg::SLOT_B0];
        b1  = snap.cap[acird_pkg::SLOT_B1];
        b2  = snap.cap[acird_pkg::SLOT_B2];
        b4  = snap.cap[acird_pkg::SLOT_B4];
        b5  = snap.cap[acird_pkg::SLOT_B5];
        b7  = snap.cap[acird_pkg::SLOT_B7];
        b8  = snap.cap[acird_pkg::SLOT_B8];
        b9  = snap.cap[acird_pkg::SLOT_B9];
        b12 = snap.cap[acird_pkg::SLOT_B12];
        b13 = snap.cap[acird_pkg::SLOT_B13];
        b14 = snap.cap[acird_pkg::SLOT_B14];
        rt  = snap.has_ifeel ? snap.cap[acird_pkg::SLOT_RT] : 8'd0;

        nblocks = (snap.kind == acird_pkg::KIND_FOUR) ? 3'd4 : 3'd3;

        // a short frame judges its unfinished block and the missing ones
        ok      = snap.sums_good;
        reached = snap.count[5:3];
        if (snap.count < {nblocks, 3'b000})
        begin
            if (snap.count[2:0] != 3'd0)
            begin
                if (snap.block_sum != 4'd0)
                begin
                    ok = 1'b0;
                end
                reached = reached + 3'd1;
            end
            if (reached < nblocks)
            begin
                ok = 1'b0;
            end
        end

        flags    = 4'd0;
        flags[1] = snap.has_ifeel;
        flags[2] = snap.has_ifeel && (snap.cap[acird_pkg::SLOT_ID] == acird_pkg::IFEEL_ID);

        rec            = '0;
        rec.frame_kind = snap.kind;

        unique case (snap.kind)
            acird_pkg::KIND_REJECT:
            begin
                rec.frame_kind = acird_pkg::KIND_REJECT;
            end
            acird_pkg::KIND_IFEEL:
            begin
                rec.check_flags = flags;
                rec.room_temp_c = rt;
            end
            default:
            begin
                flags[0] = ok;
                flags[3] = (b0 != b8) || (b1[3:0] != b9[3:0]);

                rec.check_flags    = flags;
                rec.power_on       = b0[3];
                rec.op_mode        = b0[2:0];
                rec.set_temp_c     = {1'b0, b1[3:0]} + 5'd16;
                rec.fan_level      = (b0[5:4] == 2'd3) ? b14[6:4] : {1'b0, b0[5:4]};
                rec.feature_flags  = {b5[2], b7[2], b0[6], b2[7:4]};
                rec.vane_positions = b4;
                rec.room_temp_c    = rt;

                if (b0[7])
                begin
                    rec.sleep_mode = 2'd1;
                end
                else if ((snap.kind == acird_pkg::KIND_THREE) && b12[0])
                begin
                    rec.sleep_mode = 2'd2;
                end

                case (b5[1:0])
                    2'd2:    rec.display_source = 2'd1;
                    2'd3:    rec.display_source = 2'd2;
                    default: rec.display_source = 2'd0;
                endcase

                if ((snap.kind == acird_pkg::KIND_FOUR) && (b1[7:4] >= acird_pkg::TIMER_MIN))
                begin
                    rec.timer_minutes = {b13[2:0], b12};
                end
            end
        endcase
    end

endmodule
